### src/rbst_pkg.sv
`timescale 1ns / 1ps

package rbst_pkg;

    // Quotient bits from the divider: 24 significand bits, guard, round, one spare.
    localparam int QBITS = 27;
    // Register stages inside one slab unit: 4 subtract, 1 divide setup,
    // QBITS divide steps, 1 denormal shift, 1 round, 1 near/far ordering.
    localparam int SLAB_LAT = 4 + 1 + QBITS + 3;

    localparam logic [31:0] QNAN = 32'h7FC0_0000;

    typedef logic [31:0] fp_t;

    // Subtract, after alignment.
    typedef struct packed {
        logic        sign;
        logic        is_sub;
        logic        nan;
        logic        inf;
        logic        inf_sign;
        logic        zsign;
        logic [7:0]  exp;
        logic [26:0] mx;
        logic [26:0] my;
    } sa_t;

    // Subtract, after the add.
    typedef struct packed {
        logic        sign;
        logic        nan;
        logic        inf;
        logic        inf_sign;
        logic        zsign;
        logic [7:0]  exp;
        logic [27:0] sum;
    } sb_t;

    // Normalized value ready for rounding: man[26:3] significand, G, R, sticky.
    typedef struct packed {
        logic        sign;
        logic        nan;
        logic        inf;
        logic        zero;
        logic [7:0]  ef;
        logic [26:0] man;
    } rp_t;

    // Divider step state.
    typedef struct packed {
        logic              sign;
        logic              nan;
        logic              inf;
        logic              zero;
        logic signed [10:0] e;
        logic [24:0]       rem;
        logic [23:0]       dvs;
        logic [QBITS-1:0]  q;
    } dv_t;

    function automatic logic f_is_nan(input fp_t a);
        return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    endfunction

    function automatic logic f_is_inf(input fp_t a);
        return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    endfunction

    function automatic logic f_is_zero(input fp_t a);
        return a[30:0] == 31'd0;
    endfunction

    // Ordered less-than; false on any NaN, +0 equals -0.
    function automatic logic f_lt(input fp_t a, input fp_t b);
        logic r;
        if (f_is_nan(a) || f_is_nan(b))
            r = 1'b0;
        else if (f_is_zero(a) && f_is_zero(b))
            r = 1'b0;
        else if (a[31] != b[31])
            r = a[31];
        else if (!a[31])
            r = a[30:0] < b[30:0];
        else
            r = a[30:0] > b[30:0];
        return r;
    endfunction

    function automatic logic f_le(input fp_t a, input fp_t b);
        logic eq;
        eq = !f_is_nan(a) && !f_is_nan(b) &&
             ((a == b) || (f_is_zero(a) && f_is_zero(b)));
        return f_lt(a, b) || eq;
    endfunction

    // Right shift that folds the lost bits into the lsb.
    function automatic logic [26:0] shr_jam(input logic [26:0] v, input logic [7:0] sh);
        logic [26:0] s;
        logic [26:0] mask;
        logic        st;
        if (sh >= 8'd27) begin
            s  = 27'd0;
            st = |v;
        end
        else begin
            s    = v >> sh;
            mask = ~(27'h7FF_FFFF << sh);
            st   = |(v & mask);
        end
        return {s[26:1], s[0] | st};
    endfunction

    function automatic logic [4:0] lzc27(input logic [26:0] v);
        logic [4:0] z;
        z = 5'd27;
        for (int i = 0; i < 27; i++) begin
            if (v[i])
                z = 5'(26 - i);
        end
        return z;
    endfunction

    function automatic logic [4:0] lzc24(input logic [23:0] v);
        logic [4:0] z;
        z = 5'd24;
        for (int i = 0; i < 24; i++) begin
            if (v[i])
                z = 5'(23 - i);
        end
        return z;
    endfunction

    // a - b: order by magnitude and align the smaller operand.
    function automatic sa_t sub_align(input fp_t a, input fp_t b);
        sa_t        r;
        fp_t        bn;
        fp_t        x;
        fp_t        y;
        logic       swap;
        logic [7:0] ex;
        logic [7:0] ey;
        bn   = {~b[31], b[30:0]};
        swap = bn[30:0] > a[30:0];
        x    = swap ? bn : a;
        y    = swap ? a : bn;
        ex   = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
        ey   = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
        r.sign     = x[31];
        r.is_sub   = x[31] ^ y[31];
        r.nan      = f_is_nan(a) || f_is_nan(b) ||
                     (f_is_inf(a) && f_is_inf(bn) && (a[31] != bn[31]));
        r.inf      = f_is_inf(a) || f_is_inf(bn);
        r.inf_sign = f_is_inf(a) ? a[31] : bn[31];
        r.zsign    = a[31] & bn[31];
        r.exp      = ex;
        r.mx       = {x[30:23] != 8'd0, x[22:0], 3'b000};
        r.my       = shr_jam({y[30:23] != 8'd0, y[22:0], 3'b000}, ex - ey);
        return r;
    endfunction

    function automatic sb_t sub_add(input sa_t s);
        sb_t r;
        r.sign     = s.sign;
        r.nan      = s.nan;
        r.inf      = s.inf;
        r.inf_sign = s.inf_sign;
        r.zsign    = s.zsign;
        r.exp      = s.exp;
        r.sum      = s.is_sub ? ({1'b0, s.mx} - {1'b0, s.my})
                              : ({1'b0, s.mx} + {1'b0, s.my});
        return r;
    endfunction

    function automatic rp_t sub_norm(input sb_t s);
        rp_t         r;
        logic [4:0]  z;
        logic [7:0]  lim;
        logic [7:0]  sh;
        logic [8:0]  e9;
        logic [26:0] m;
        logic        zero;
        logic        ovf;
        zero = s.sum == 28'd0;
        z    = lzc27(s.sum[26:0]);
        lim  = s.exp - 8'd1;
        sh   = ({3'b000, z} < lim) ? {3'b000, z} : lim;
        if (s.sum[27]) begin
            m  = {s.sum[27:2], s.sum[1] | s.sum[0]};
            e9 = {1'b0, s.exp} + 9'd1;
        end
        else begin
            m  = s.sum[26:0] << sh;
            e9 = {1'b0, s.exp} - {1'b0, sh};
        end
        ovf    = (e9 >= 9'd255) && !zero;
        r.nan  = s.nan;
        r.inf  = s.inf || ovf;
        r.zero = zero;
        r.sign = s.inf ? s.inf_sign : (zero ? s.zsign : s.sign);
        r.ef   = m[26] ? e9[7:0] : 8'd0;
        r.man  = m;
        return r;
    endfunction

    function automatic fp_t rp_round(input rp_t r);
        fp_t         f;
        logic        rup;
        logic [31:0] body;
        rup  = r.man[2] & (r.man[1] | r.man[0] | r.man[3]);
        body = {1'b0, r.ef, r.man[25:3]} + {31'd0, rup};
        if (r.nan)
            f = QNAN;
        else if (r.inf)
            f = {r.sign, 8'hFF, 23'd0};
        else if (r.zero)
            f = {r.sign, 31'd0};
        else
            f = {r.sign, body[30:0]};
        return f;
    endfunction

    // a / b: specials, normalize subnormal operands, seed the remainder.
    function automatic dv_t div_prep(input fp_t a, input fp_t b);
        dv_t         r;
        logic [23:0] ma;
        logic [23:0] mb;
        logic [4:0]  za;
        logic [4:0]  zb;
        logic [7:0]  ea;
        logic [7:0]  eb;
        ma   = {a[30:23] != 8'd0, a[22:0]};
        mb   = {b[30:23] != 8'd0, b[22:0]};
        za   = lzc24(ma);
        zb   = lzc24(mb);
        ea   = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb   = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        r.sign = a[31] ^ b[31];
        r.nan  = f_is_nan(a) || f_is_nan(b) || (f_is_zero(a) && f_is_zero(b)) ||
                 (f_is_inf(a) && f_is_inf(b));
        r.inf  = f_is_inf(a) || f_is_zero(b);
        r.zero = f_is_zero(a) || f_is_inf(b);
        r.e    = 11'(ea) - 11'(za) - 11'(eb) + 11'(zb) + 11'd127;
        r.rem  = {1'b0, ma << za};
        r.dvs  = mb << zb;
        r.q    = '0;
        return r;
    endfunction

    function automatic dv_t div_step(input dv_t s);
        dv_t         r;
        logic        ge;
        logic [24:0] dif;
        r     = s;
        ge    = s.rem >= {1'b0, s.dvs};
        dif   = ge ? (s.rem - {1'b0, s.dvs}) : s.rem;
        r.rem = {dif[23:0], 1'b0};
        r.q   = {s.q[QBITS-2:0], ge};
        return r;
    endfunction

    // Pick the quotient window, then shift into the subnormal range if needed.
    function automatic rp_t div_shift(input dv_t s);
        rp_t               r;
        logic [26:0]       m;
        logic signed [10:0] e;
        logic [7:0]        sh;
        logic              rnz;
        rnz = s.rem != 25'd0;
        if (s.q[QBITS-1]) begin
            m = {s.q[26:1], s.q[0] | rnz};
            e = s.e;
        end
        else begin
            m = {s.q[25:0], rnz};
            e = s.e - 11'sd1;
        end
        if (e <= 11'sd0) begin
            sh   = (e < -11'sd26) ? 8'd27 : 8'(11'sd1 - e);
            m    = shr_jam(m, sh);
            r.ef = 8'd0;
        end
        else begin
            r.ef = e[7:0];
        end
        r.sign = s.sign;
        r.nan  = s.nan;
        r.zero = s.zero;
        r.inf  = s.inf || ((e >= 11'sd255) && !s.zero);
        r.man  = m;
        return r;
    endfunction

endpackage

### src/rbst_slab.sv
`timescale 1ns / 1ps

// One axis: t = (lo - o) / d and (hi - o) / d, ordered near <= far.
// Lane 0 carries the lo plane, lane 1 the hi plane.
module rbst_slab
(
    input  logic           clk,
    input  logic           en,
    input  rbst_pkg::fp_t  o,
    input  rbst_pkg::fp_t  d,
    input  rbst_pkg::fp_t  lo,
    input  rbst_pkg::fp_t  hi,
    output rbst_pkg::fp_t  near_t,
    output rbst_pkg::fp_t  far_t
);

    rbst_pkg::sa_t sa_reg [2];
    rbst_pkg::sb_t sb_reg [2];
    rbst_pkg::rp_t sc_reg [2];
    rbst_pkg::fp_t sd_reg [2];
    rbst_pkg::fp_t dir_reg [4];
    rbst_pkg::dv_t dv_reg [rbst_pkg::QBITS+1][2];
    rbst_pkg::rp_t dn_reg [2];
    rbst_pkg::fp_t qt_reg [2];
    rbst_pkg::fp_t near_reg;
    rbst_pkg::fp_t far_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sa_reg[0] <= rbst_pkg::sub_align(lo, o);
            sa_reg[1] <= rbst_pkg::sub_align(hi, o);
            dir_reg[0] <= d;
            for (int k = 1; k < 4; k++)
            begin
                dir_reg[k] <= dir_reg[k-1];
            end
            for (int l = 0; l < 2; l++)
            begin
                sb_reg[l]    <= rbst_pkg::sub_add(sa_reg[l]);
                sc_reg[l]    <= rbst_pkg::sub_norm(sb_reg[l]);
                sd_reg[l]    <= rbst_pkg::rp_round(sc_reg[l]);
                dv_reg[0][l] <= rbst_pkg::div_prep(sd_reg[l], dir_reg[3]);
                for (int k = 1; k <= rbst_pkg::QBITS; k++)
                begin
                    dv_reg[k][l] <= rbst_pkg::div_step(dv_reg[k-1][l]);
                end
                dn_reg[l] <= rbst_pkg::div_shift(dv_reg[rbst_pkg::QBITS][l]);
                qt_reg[l] <= rbst_pkg::rp_round(dn_reg[l]);
            end
            // swap when lo-plane t exceeds hi-plane t; NaN never swaps
            if (rbst_pkg::f_lt(qt_reg[1], qt_reg[0]))
            begin
                near_reg <= qt_reg[1];
                far_reg  <= qt_reg[0];
            end
            else
            begin
                near_reg <= qt_reg[0];
                far_reg  <= qt_reg[1];
            end
        end
    end

    assign near_t = near_reg;
    assign far_t  = far_reg;

endmodule

### src/ray_box_slab_test.sv
`timescale 1ns / 1ps

// Channel | direction | handshake            | payload
// --------+-----------+----------------------+-------------------------------------------
// input   | in        | in_valid / in_stall  | ray_origin_*, ray_dir_*, box_lo_*, box_hi_*
// output  | out       | out_valid / out_stall| hit, distance_valid, hit_distance
//
// One transfer is taken every cycle while no result is held by a stalled sink.
// Most of the pipe is the divider: one restoring quotient bit per stage,
// 27 stages, behind a 4-stage subtract and ahead of denormal shift, round and ordering.
// Reset clears only the valid bits; payload registers hold whatever they had.
// A stalled result freezes the whole pipe in place, and in_stall rises in
// the same cycle, so no transfer is lost or repeated.
module ray_box_slab_test
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] ray_origin_x,
    input  logic [31:0] ray_origin_y,
    input  logic [31:0] ray_origin_z,
    input  logic [31:0] ray_dir_x,
    input  logic [31:0] ray_dir_y,
    input  logic [31:0] ray_dir_z,
    input  logic [31:0] box_lo_x,
    input  logic [31:0] box_lo_y,
    input  logic [31:0] box_lo_z,
    input  logic [31:0] box_hi_x,
    input  logic [31:0] box_hi_y,
    input  logic [31:0] box_hi_z,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        hit,
    output logic        distance_valid,
    output logic [31:0] hit_distance
);

    localparam int LAT = rbst_pkg::SLAB_LAT;

    logic           en;
    logic           org_in_box;
    rbst_pkg::fp_t  nx;
    rbst_pkg::fp_t  fx;
    rbst_pkg::fp_t  ny;
    rbst_pkg::fp_t  fy;
    rbst_pkg::fp_t  nz;
    rbst_pkg::fp_t  fz;

    // valid bits and the inside flag ride alongside the slab units
    logic [LAT-1:0] v_reg;
    logic [LAT-1:0] ins_reg;

    // first combine stage: x narrowed by y
    logic           c1_v_reg;
    logic           c1_ins_reg;
    logic           c1_ok_reg;
    rbst_pkg::fp_t  c1_tmin_reg;
    rbst_pkg::fp_t  c1_tmax_reg;
    rbst_pkg::fp_t  c1_nz_reg;
    rbst_pkg::fp_t  c1_fz_reg;

    // output register
    logic           out_v_reg;
    logic           hit_reg;
    logic           dval_reg;
    rbst_pkg::fp_t  dist_reg;

    logic           okz;
    rbst_pkg::fp_t  tmin2;

    // Advance everything unless a finished result is held by the sink.
    assign en       = !out_v_reg || !out_stall;
    assign in_stall = !en;

    // Origin inside the box, faces included.
    assign org_in_box = rbst_pkg::f_le(box_lo_x, ray_origin_x) &&
                        rbst_pkg::f_le(ray_origin_x, box_hi_x) &&
                        rbst_pkg::f_le(box_lo_y, ray_origin_y) &&
                        rbst_pkg::f_le(ray_origin_y, box_hi_y) &&
                        rbst_pkg::f_le(box_lo_z, ray_origin_z) &&
                        rbst_pkg::f_le(ray_origin_z, box_hi_z);

    rbst_slab u_slab_x
    (
        .clk    (clk),
        .en     (en),
        .o      (ray_origin_x),
        .d      (ray_dir_x),
        .lo     (box_lo_x),
        .hi     (box_hi_x),
        .near_t (nx),
        .far_t  (fx)
    );

    rbst_slab u_slab_y
    (
        .clk    (clk),
        .en     (en),
        .o      (ray_origin_y),
        .d      (ray_dir_y),
        .lo     (box_lo_y),
        .hi     (box_hi_y),
        .near_t (ny),
        .far_t  (fy)
    );

    rbst_slab u_slab_z
    (
        .clk    (clk),
        .en     (en),
        .o      (ray_origin_z),
        .d      (ray_dir_z),
        .lo     (box_lo_z),
        .hi     (box_hi_z),
        .near_t (nz),
        .far_t  (fz)
    );

    // Valid bits: reset clears them.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg     <= '0;
            c1_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg     <= {v_reg[LAT-2:0], in_valid};
            c1_v_reg  <= v_reg[LAT-1];
            out_v_reg <= c1_v_reg;
        end
    end

    // Second combine stage: narrow by z, decide hit.
    assign okz   = c1_ok_reg &&
                   rbst_pkg::f_lt(c1_tmin_reg, c1_fz_reg) &&
                   rbst_pkg::f_lt(c1_nz_reg, c1_tmax_reg);
    assign tmin2 = rbst_pkg::f_lt(c1_tmin_reg, c1_nz_reg) ? c1_nz_reg : c1_tmin_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ins_reg <= {ins_reg[LAT-2:0], org_in_box};

            c1_ins_reg  <= ins_reg[LAT-1];
            c1_ok_reg   <= rbst_pkg::f_lt(nx, fy) && rbst_pkg::f_lt(ny, fx);
            c1_tmin_reg <= rbst_pkg::f_lt(nx, ny) ? ny : nx;
            c1_tmax_reg <= rbst_pkg::f_lt(fy, fx) ? fy : fx;
            c1_nz_reg   <= nz;
            c1_fz_reg   <= fz;

            if (c1_ins_reg)
            begin
                hit_reg  <= 1'b1;
                dval_reg <= 1'b0;
                dist_reg <= '0;
            end
            else if (okz)
            begin
                // report entry even when behind the origin; hit needs t > 0
                hit_reg  <= rbst_pkg::f_lt(32'd0, tmin2);
                dval_reg <= 1'b1;
                dist_reg <= rbst_pkg::f_is_nan(tmin2) ? rbst_pkg::QNAN : tmin2;
            end
            else
            begin
                hit_reg  <= 1'b0;
                dval_reg <= 1'b0;
                dist_reg <= '0;
            end
        end
    end

    assign out_valid      = out_v_reg;
    assign hit            = hit_reg;
    assign distance_valid = dval_reg;
    assign hit_distance   = dist_reg;

endmodule

### src/rbst_checker.sv
`timescale 1ns / 1ps

module rbst_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        hit,
    input logic        distance_valid,
    input logic [31:0] hit_distance
);

    // held result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // input stalls exactly when a result is held
    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall out of step with output");

    a_no_dist: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !distance_valid |-> hit_distance == 32'd0)
        else $error("distance given without overlap");

    // a hit with a distance means entry strictly ahead of the origin
    a_hit_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && distance_valid && hit |->
            !hit_distance[31] && (hit_distance[30:0] != 31'd0))
        else $error("hit reported with non-positive distance");

    a_no_nan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && distance_valid |->
            !((hit_distance[30:23] == 8'hFF) && (hit_distance[22:0] != 23'd0)))
        else $error("NaN distance reported");

endmodule

bind ray_box_slab_test rbst_checker u_rbst_checker (.*);
